>>> hw/rtl/tsh_pkg.sv
// Shared types and constants of the trace-set header parser.
// No dependencies; used by tsh_parser, tsh_result and trace_set_header_parser.
package tsh_pkg;

  localparam int unsigned MAX_LENGTH_BYTES = 4;
  localparam logic [7:0]  FLOAT_CODING_RST = 8'd20;

  localparam logic [7:0]  TAG_TRACES  = 8'h41;
  localparam logic [7:0]  TAG_SAMPLES = 8'h42;
  localparam logic [7:0]  TAG_CODING  = 8'h43;
  localparam logic [7:0]  TAG_DATA    = 8'h44;
  localparam logic [7:0]  TAG_TITLE   = 8'h45;
  localparam logic [7:0]  TAG_YSCALE  = 8'h4C;
  localparam logic [7:0]  TAG_END     = 8'h5F;

  localparam logic [31:0] ONE_POINT_ZERO = 32'h3F80_0000;

  // seen flag bit positions
  localparam int unsigned SEEN_TRACES  = 0;
  localparam int unsigned SEEN_SAMPLES = 1;
  localparam int unsigned SEEN_CODING  = 2;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_LEN_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] traces;
    logic [31:0] samples;
    logic [31:0] coding;
    logic [31:0] yscale;
    logic [31:0] datasize;
    logic [31:0] titlesize;
    logic [2:0]  seen;
  } capt_t;

  typedef struct packed {
    logic        emit;
    logic        len_err;
    logic [31:0] offset;
  } evt_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] trace_count;
    logic [31:0] sample_count;
    logic [31:0] coding_value;
    logic [31:0] y_scale_bits;
    logic [31:0] crypto_data_size;
    logic [31:0] title_len;
    logic [39:0] trace_bytes;
    logic [31:0] header_length;
  } res_t;

endpackage

>>> hw/rtl/trace_set_header_parser.sv
// Trace-set header parser, top level.
// Latency: a result word is registered at the edge that takes the byte that
// completes the end tag's value or carries a bad length; valid the next cycle.
// Throughput: one byte per cycle, held off only while a result word waits.
// Reset (rst_n low, synchronous): parser back to tag phase, captures cleared,
// float coding register back to 20, no result pending.
module trace_set_header_parser #(
  parameter int unsigned MAX_LENGTH_BYTES = tsh_pkg::MAX_LENGTH_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_trace_count,
  output logic [31:0] out_sample_count,
  output logic [31:0] out_coding_value,
  output logic [31:0] out_y_scale_bits,
  output logic [31:0] out_crypto_data_size,
  output logic [31:0] out_title_len,
  output logic [39:0] out_trace_bytes,
  output logic [31:0] out_header_length
);
  import tsh_pkg::*;

  logic  take;
  capt_t capt;
  evt_t  evt;
  res_t  res;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  tsh_parser #(
    .MaxLenBytes (MAX_LENGTH_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .data_byte   (in_data_byte),
    .restart     (in_restart),
    .capt        (capt),
    .evt         (evt)
  );

  tsh_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (take && in_restart),
    .capt      (capt),
    .evt       (evt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_status           = res.status;
  assign out_trace_count      = res.trace_count;
  assign out_sample_count     = res.sample_count;
  assign out_coding_value     = res.coding_value;
  assign out_y_scale_bits     = res.y_scale_bits;
  assign out_crypto_data_size = res.crypto_data_size;
  assign out_title_len        = res.title_len;
  assign out_trace_bytes      = res.trace_bytes;
  assign out_header_length    = res.header_length;

endmodule

>>> hw/rtl/tsh_parser.sv
// Byte-level header parser: tag/length/value walk, captures and byte count.
// Depends on tsh_pkg.
module tsh_parser #(
  parameter int unsigned MaxLenBytes = tsh_pkg::MAX_LENGTH_BYTES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          restart,
  output tsh_pkg::capt_t capt,
  output tsh_pkg::evt_t  evt
);
  import tsh_pkg::*;

  localparam int unsigned LW = $clog2(MaxLenBytes + 1);

  typedef enum logic [2:0] {
    PH_TAG, PH_LEN, PH_EXTLEN, PH_VALUE, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [31:0] vlen_r, vlen_nxt;
  logic [31:0] vidx_r, vidx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] off_r, off_nxt;
  logic [7:0]  fcode_r, fcode_nxt;
  capt_t       capt_r, capt_nxt;
  logic        emit, len_err;

  always_comb begin
    logic        fin;
    logic [31:0] fin_val;
    logic [31:0] shifted;
    logic [31:0] acc_new;
    logic [31:0] len_new;
    logic [6:0]  n;

    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    left_nxt  = left_r;
    vlen_nxt  = vlen_r;
    vidx_nxt  = vidx_r;
    acc_nxt   = acc_r;
    off_nxt   = off_r;
    capt_nxt  = capt_r;
    fcode_nxt = cfg_wr_en ? cfg_wr_data : fcode_r;
    emit      = 1'b0;
    len_err   = 1'b0;
    fin       = 1'b0;
    fin_val   = '0;
    n         = data_byte[6:0];
    shifted   = {24'b0, data_byte} << {vidx_r[1:0], 3'b000};
    acc_new   = (vidx_r < 32'd4) ? (acc_r | shifted) : acc_r;
    len_new   = vlen_r | shifted;

    if (take) begin
      if (restart) begin
        // restart byte is the tag of a fresh header
        phase_nxt = PH_LEN;
        tag_nxt   = data_byte;
        left_nxt  = '0;
        vlen_nxt  = '0;
        vidx_nxt  = '0;
        acc_nxt   = '0;
        off_nxt   = 32'd1;
        capt_nxt  = '0;
      end else if (phase_r != PH_DONE) begin
        off_nxt = off_r + 32'd1;
        unique case (phase_r)
          PH_TAG: begin
            tag_nxt   = data_byte;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            if (data_byte[7]) begin
              if (32'(n) > 32'(MaxLenBytes)) begin
                emit      = 1'b1;
                len_err   = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                vlen_nxt = '0;
                vidx_nxt = '0;
                acc_nxt  = '0;
                if (n == 7'd0) begin
                  fin = 1'b1;
                end else begin
                  left_nxt  = n[LW-1:0];
                  phase_nxt = PH_EXTLEN;
                end
              end
            end else begin
              vlen_nxt = {24'b0, data_byte};
              vidx_nxt = '0;
              acc_nxt  = '0;
              if (data_byte == 8'd0) fin = 1'b1;
              else phase_nxt = PH_VALUE;
            end
          end
          PH_EXTLEN: begin
            vlen_nxt = len_new;
            vidx_nxt = vidx_r + 32'd1;
            left_nxt = left_r - LW'(1);
            if (left_r == LW'(1)) begin
              vidx_nxt = '0;
              acc_nxt  = '0;
              if (len_new == 32'd0) fin = 1'b1;
              else phase_nxt = PH_VALUE;
            end
          end
          PH_VALUE: begin
            acc_nxt  = acc_new;
            vidx_nxt = vidx_r + 32'd1;
            if (vidx_r + 32'd1 == vlen_r) begin
              fin     = 1'b1;
              fin_val = acc_new;
            end
          end
          default: phase_nxt = PH_DONE;
        endcase

        if (fin) begin
          case (tag_r)
            TAG_TRACES: begin
              capt_nxt.traces = fin_val;
              capt_nxt.seen[SEEN_TRACES] = 1'b1;
            end
            TAG_SAMPLES: begin
              capt_nxt.samples = fin_val;
              capt_nxt.seen[SEEN_SAMPLES] = 1'b1;
            end
            TAG_CODING: begin
              capt_nxt.coding = fin_val;
              capt_nxt.seen[SEEN_CODING] = 1'b1;
              if (fin_val == {24'b0, fcode_r}) capt_nxt.yscale = ONE_POINT_ZERO;
            end
            TAG_DATA:   capt_nxt.datasize  = fin_val;
            TAG_TITLE:  capt_nxt.titlesize = fin_val;
            TAG_YSCALE: capt_nxt.yscale    = fin_val;
            default: ;
          endcase
          if (tag_r == TAG_END) begin
            emit      = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_TAG;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      tag_r   <= '0;
      left_r  <= '0;
      vlen_r  <= '0;
      vidx_r  <= '0;
      acc_r   <= '0;
      off_r   <= '0;
      capt_r  <= '0;
      fcode_r <= FLOAT_CODING_RST;
    end else begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      left_r  <= left_nxt;
      vlen_r  <= vlen_nxt;
      vidx_r  <= vidx_nxt;
      acc_r   <= acc_nxt;
      off_r   <= off_nxt;
      capt_r  <= capt_nxt;
      fcode_r <= fcode_nxt;
    end
  end

  // captures seen by the result stage are the ones before this word; the end
  // tag and a length error never change them
  assign capt        = capt_r;
  assign evt.emit    = emit;
  assign evt.len_err = len_err;
  assign evt.offset  = off_nxt;

  a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> phase_r == PH_DONE)
    else $error("parser not stopped after result");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && !(take && restart)) |-> !emit && off_nxt == off_r)
    else $error("word counted after result");

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EXTLEN |-> left_r != '0 && 32'(left_r) <= 32'(MaxLenBytes))
    else $error("length byte count out of range");

endmodule

>>> hw/rtl/tsh_result.sv
// Result register: status, trace record size and output hold.
// Depends on tsh_pkg; fed by tsh_parser.
module tsh_result (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clear,
  input  tsh_pkg::capt_t capt,
  input  tsh_pkg::evt_t  evt,
  input  logic           out_ready,
  output logic           out_valid,
  output tsh_pkg::res_t  res
);
  import tsh_pkg::*;

  logic [35:0] prod_r, prod_nxt;
  logic        valid_r, valid_nxt;
  res_t        res_r, res_nxt;
  status_t     status;

  // samples * bytes-per-sample, registered from the captures; a capture can
  // never be followed by a result in the next word
  assign prod_nxt = clear ? '0 : capt.samples * {32'b0, capt.coding[3:0]};

  always_comb begin
    if (evt.len_err)
      status = STATUS_LEN_ERR;
    else if (capt.seen != 3'b111 || capt.coding == 32'd0)
      status = STATUS_MISSING;
    else
      status = STATUS_OK;
  end

  always_comb begin
    res_nxt   = res_r;
    valid_nxt = valid_r && !out_ready;
    if (evt.emit) begin
      valid_nxt                = 1'b1;
      res_nxt.status           = status;
      res_nxt.trace_count      = capt.traces;
      res_nxt.sample_count     = capt.samples;
      res_nxt.coding_value     = capt.coding;
      res_nxt.y_scale_bits     = capt.yscale;
      res_nxt.crypto_data_size = capt.datasize;
      res_nxt.title_len        = capt.titlesize;
      res_nxt.trace_bytes      = 40'(prod_r) + 40'(capt.datasize) + 40'(capt.titlesize);
      res_nxt.header_length    = evt.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      prod_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      prod_r  <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign res       = res_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    evt.emit |-> !valid_r || out_ready)
    else $error("result word overwritten");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    evt.emit |=> valid_r)
    else $error("result word lost");

  a_ok_coding: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && res_r.status == STATUS_OK) |-> res_r.coding_value != 32'd0)
    else $error("ok status with zero coding");

endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for trace_set_header_parser: drives header byte streams,
// predicts each header summary and checks every result word field by field.
// Depends on tsh_pkg and the trace_set_header_parser RTL.
`timescale 1ns / 100ps

module testbench;
  import tsh_pkg::*;

  class tsh_scoreboard;
    typedef enum logic [2:0] {SEEK_TAG, SEEK_LEN, SEEK_EXTLEN, IN_VALUE, HALTED} phase_t;

    res_t        expected_headers[$];
    int unsigned errors;
    logic [7:0]  float_coding;

    phase_t      phase;
    logic [7:0]  tag;
    logic [2:0]  len_left;
    logic [31:0] val_len;
    logic [31:0] val_idx;
    logic [31:0] acc;
    capt_t       capt;
    logic [31:0] offset;
    logic        len_err;

    function new();
      errors = 0;
      float_coding = FLOAT_CODING_RST;
      restart_parse();
    endfunction

    function void restart_parse();
      phase = SEEK_TAG;
      tag = '0;
      len_left = '0;
      val_len = '0;
      val_idx = '0;
      acc = '0;
      capt = '0;
      offset = '0;
      len_err = 1'b0;
    endfunction

    function void finish_header();
      res_t r;
      if (len_err)
        r.status = STATUS_LEN_ERR;
      else if (!(capt.seen[SEEN_TRACES] && capt.seen[SEEN_SAMPLES] &&
                 capt.seen[SEEN_CODING]) || capt.coding == '0)
        r.status = STATUS_MISSING;
      else
        r.status = STATUS_OK;
      r.trace_count      = capt.traces;
      r.sample_count     = capt.samples;
      r.coding_value     = capt.coding;
      r.y_scale_bits     = capt.yscale;
      r.crypto_data_size = capt.datasize;
      r.title_len        = capt.titlesize;
      r.trace_bytes      = 40'(capt.samples) * 40'(capt.coding[3:0])
                           + 40'(capt.datasize) + 40'(capt.titlesize);
      r.header_length    = offset;
      expected_headers.push_back(r);
      phase = HALTED;
    endfunction

    function void close_entry();
      case (tag)
        TAG_TRACES: begin
          capt.traces = acc;
          capt.seen[SEEN_TRACES] = 1'b1;
        end
        TAG_SAMPLES: begin
          capt.samples = acc;
          capt.seen[SEEN_SAMPLES] = 1'b1;
        end
        TAG_CODING: begin
          capt.coding = acc;
          capt.seen[SEEN_CODING] = 1'b1;
          if (acc == {24'h0, float_coding})
            capt.yscale = ONE_POINT_ZERO;
        end
        TAG_DATA:   capt.datasize = acc;
        TAG_TITLE:  capt.titlesize = acc;
        TAG_YSCALE: capt.yscale = acc;
        default: ;
      endcase
      if (tag == TAG_END)
        finish_header();
      else
        phase = SEEK_TAG;
    endfunction

    function void open_value();
      val_idx = '0;
      acc = '0;
      if (val_len == '0)
        close_entry();
      else
        phase = IN_VALUE;
    endfunction

    // one accepted input word
    function void take_byte(logic [7:0] b, logic rs);
      if (rs)
        restart_parse();
      if (phase == HALTED)
        return;
      offset++;
      case (phase)
        SEEK_TAG: begin
          tag = b;
          phase = SEEK_LEN;
        end
        SEEK_LEN: begin
          if (b[7]) begin
            if (b[6:0] > MAX_LENGTH_BYTES) begin
              len_err = 1'b1;
              finish_header();
            end else begin
              val_len = '0;
              val_idx = '0;
              if (b[6:0] == '0)
                open_value();
              else begin
                len_left = b[2:0];
                phase = SEEK_EXTLEN;
              end
            end
          end else begin
            val_len = 32'(b);
            open_value();
          end
        end
        SEEK_EXTLEN: begin
          if (val_idx < 4)
            val_len |= 32'(b) << (8 * val_idx);
          val_idx++;
          len_left--;
          if (len_left == '0)
            open_value();
        end
        IN_VALUE: begin
          if (val_idx < 4)
            acc |= 32'(b) << (8 * val_idx);
          val_idx++;
          if (val_idx == val_len)
            close_entry();
        end
        default: phase = HALTED;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task cmp(string field, logic [39:0] got, logic [39:0] want);
      if (got !== want)
        report($sformatf("%s got %0h, expected %0h", field, got, want));
    endtask

    task check_header(res_t got);
      res_t want;
      if (expected_headers.size() == 0) begin
        report("result word with no header pending");
        return;
      end
      want = expected_headers.pop_front();
      cmp("status", 40'(got.status), 40'(want.status));
      cmp("trace_count", 40'(got.trace_count), 40'(want.trace_count));
      cmp("sample_count", 40'(got.sample_count), 40'(want.sample_count));
      cmp("coding_value", 40'(got.coding_value), 40'(want.coding_value));
      cmp("y_scale_bits", 40'(got.y_scale_bits), 40'(want.y_scale_bits));
      cmp("crypto_data_size", 40'(got.crypto_data_size), 40'(want.crypto_data_size));
      cmp("title_len", 40'(got.title_len), 40'(want.title_len));
      cmp("trace_bytes", got.trace_bytes, want.trace_bytes);
      cmp("header_length", 40'(got.header_length), 40'(want.header_length));
    endtask
  endclass

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SEG_WORDS   = 242;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } hdr_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_trace_count;
  logic [31:0] out_sample_count;
  logic [31:0] out_coding_value;
  logic [31:0] out_y_scale_bits;
  logic [31:0] out_crypto_data_size;
  logic [31:0] out_title_len;
  logic [39:0] out_trace_bytes;
  logic [31:0] out_header_length;

  tsh_scoreboard sb;
  hdr_word_t     stim_q[$];
  int unsigned   send_idle = 10;
  int unsigned   recv_idle = 79;
  int unsigned   stalled_cycles = 0;

  trace_set_header_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_restart           (in_restart),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_trace_count      (out_trace_count),
    .out_sample_count     (out_sample_count),
    .out_coding_value     (out_coding_value),
    .out_y_scale_bits     (out_y_scale_bits),
    .out_crypto_data_size (out_crypto_data_size),
    .out_title_len        (out_title_len),
    .out_trace_bytes      (out_trace_bytes),
    .out_header_length    (out_header_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.take_byte(in_data_byte, in_restart);
      if (out_valid && out_ready)
        sb.check_header('{status_t'(out_status), out_trace_count, out_sample_count,
                          out_coding_value, out_y_scale_bits, out_crypto_data_size,
                          out_title_len, out_trace_bytes, out_header_length});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stalled_cycles <= 0;
      else
        stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_word(input hdr_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= w.data;
    in_restart <= w.restart;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_stream();
    foreach (stim_q[i])
      send_word(stim_q[i]);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_headers.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_float_coding(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.float_coding = v;
  endtask

  // lf < 0: short length byte; otherwise 0x80|lf followed by lf length bytes
  function automatic void add_entry(input logic [7:0] tg, input int unsigned nb,
                                    input logic [31:0] v, input int lf);
    stim_q.push_back('{1'b0, tg});
    if (lf < 0)
      stim_q.push_back('{1'b0, 8'(nb)});
    else begin
      stim_q.push_back('{1'b0, 8'h80 | 8'(lf)});
      for (int i = 0; i < lf; i++)
        stim_q.push_back('{1'b0, 8'(nb >> (8 * i))});
    end
    for (int i = 0; i < nb; i++)
      stim_q.push_back('{1'b0, (i < 4) ? v[8 * i +: 8] : 8'($urandom)});
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  function automatic void random_header(input logic [7:0] fc);
    int unsigned first, entries, r, nb;
    int          lf;
    logic [7:0]  tg;
    logic [31:0] v;
    first = stim_q.size();
    entries = $urandom_range(1, 7);
    for (int e = 0; e <= entries; e++) begin
      r = $urandom_range(99);
      if (e == entries)
        tg = TAG_END;
      else if (r < 15) tg = TAG_TRACES;
      else if (r < 30) tg = TAG_SAMPLES;
      else if (r < 45) tg = TAG_CODING;
      else if (r < 57) tg = TAG_DATA;
      else if (r < 67) tg = TAG_TITLE;
      else if (r < 77) tg = TAG_YSCALE;
      else begin
        tg = 8'($urandom);
        if (tg == TAG_END)
          tg = 8'h00;
      end
      // bad length field: block reports at once and stops
      if ($urandom_range(99) < 3) begin
        stim_q.push_back('{1'b0, tg});
        stim_q.push_back('{1'b0, 8'h80 | 8'($urandom_range(MAX_LENGTH_BYTES + 1, 127))});
        break;
      end
      r = $urandom_range(99);
      if (r < 8)        nb = 0;
      else if (r < 90)  nb = $urandom_range(1, 4);
      else if (r < 98)  nb = $urandom_range(5, 9);
      else              nb = $urandom_range(60, 127);
      if (tg == TAG_END)
        nb = $urandom_range(3);
      lf = ($urandom_range(99) < 75) ? -1 : int'($urandom_range(MAX_LENGTH_BYTES));
      if (lf == 0)
        nb = 0;
      if (tg == TAG_CODING && $urandom_range(2) == 0)
        v = {24'h0, fc};
      else
        v = pick_value();
      add_entry(tg, nb, v, lf);
    end
    stim_q[first].restart = 1'b1;
  endfunction

  initial begin : stimulus
    int unsigned sent, useful, r, cut, n;
    logic [7:0]  fc;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // full header: 4-byte all-ones count, 5-byte samples value behind an
    // extended length, float coding, empty end tag; then ignored trailing word
    stim_q.delete();
    add_entry(TAG_TRACES, 4, 32'hFFFF_FFFF, -1);
    add_entry(TAG_SAMPLES, 5, 32'h0403_0201, 1);
    add_entry(TAG_CODING, 1, 32'(FLOAT_CODING_RST), -1);
    add_entry(TAG_END, 0, 32'h0, -1);
    stim_q[0].restart = 1'b1;
    stim_q.push_back('{1'b0, 8'hAA});
    // bare end tag with 0x80 length: required tags missing
    stim_q.push_back('{1'b1, TAG_END});
    stim_q.push_back('{1'b0, 8'h80});
    // length field too long, then a word that must be ignored
    stim_q.push_back('{1'b1, TAG_TRACES});
    stim_q.push_back('{1'b0, 8'h80 | 8'(MAX_LENGTH_BYTES + 1)});
    stim_q.push_back('{1'b0, 8'h00});
    send_stream();

    for (int seg = 0; seg < 6; seg++) begin
      send_idle = (seg < 2) ? 10 : (seg < 4) ? 79 : 0;
      recv_idle = (seg < 2) ? 79 : (seg < 4) ? 10 : 0;
      if (seg > 0) begin
        drain();
        repeat (4) @(posedge clk);
        case (seg)
          1:       fc = 8'h00;
          2:       fc = 8'hFF;
          4:       fc = FLOAT_CODING_RST;
          default: fc = 8'($urandom);
        endcase
        write_float_coding(fc);
      end
      sent = 0;
      while (sent < SEG_WORDS) begin
        stim_q.delete();
        r = $urandom_range(99);
        if (r < 90) begin
          random_header(sb.float_coding);
          if (r >= 80 && stim_q.size() > 1) begin
            // broken header, abandoned by the next restart
            cut = $urandom_range(1, stim_q.size() - 1);
            while (stim_q.size() > cut)
              void'(stim_q.pop_back());
          end
        end else begin
          n = $urandom_range(3, 12);
          for (int i = 0; i < n; i++)
            stim_q.push_back('{(i == 0) || ($urandom_range(19) == 0), 8'($urandom)});
        end
        useful = stim_q.size();
        if ($urandom_range(3) == 0) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            stim_q.push_back('{1'b0, 8'($urandom)});
        end
        send_stream();
        sent += useful;
        if ($urandom_range(49) == 0)
          drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_headers.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
